/* rtl/core/assert_macros.svh */
// Assertion macros included by the top-level RTL file; they sample on clk and are off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/bbs_pkg.sv */
// Package for the bitmap bit-ops and search unit: field widths, defaults, command codes.
package bbs_pkg;

  localparam int BITMAP_BITS_DEF = 1024;
  localparam int WORD_BITS_DEF   = 32;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int CFG_W  = 11;

  localparam int IN_TDATA_W  = 16;  // cmd + bit_index, padded to bytes
  localparam int OUT_TDATA_W = 16;  // old_bit + found + found_index, padded

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  localparam logic [CMD_W-1:0] CMD_TEST  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TSET  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TCLR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FZERO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FONE  = 3'd6;

endpackage

/* rtl/core/bbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bitmap_bit_ops_and_search_unit.sv */
// Top level: bitmap with test/set/clear ops and forward bit searches over a word RAM.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in_     | input     | in_tvalid/in_tready  | in_tdata: cmd, bit_index
//  out_    | output    | out_tvalid/out_tready| out_tdata: old_bit, found, found_index
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_data: bits_in_use
//
//  One request at a time. Bit ops pass through ST_WORD and ST_DONE; out_tvalid rises and
//  in_tready returns as the state goes back to ST_IDLE. Searches read one word per cycle,
//  up to BITMAP_BITS/WORD_BITS words per request, stopping at a match or at the limit.
//  After reset a clearing pass writes zeros to all BITMAP_BITS/WORD_BITS words; in_tready
//  stays low meanwhile, cfg writes are taken always. A result held by out_tready low stalls
//  the next request in ST_DONE.
module bitmap_bit_ops_and_search_unit #(
  parameter int BITMAP_BITS = bbs_pkg::BITMAP_BITS_DEF,
  parameter int WORD_BITS   = bbs_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bbs_pkg::IN_TDATA_W-1:0]  in_tdata,   // [2:0] cmd, [12:3] bit_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbs_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] old_bit, [1] found,
                                                      // [11:2] found_index
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbs_pkg::CFG_W-1:0]       cfg_data
);

  import bbs_pkg::*;

  localparam int NUM_WORDS = BITMAP_BITS / WORD_BITS;
  localparam int POS_W     = $clog2(BITMAP_BITS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int AW        = (POS_W > OFF_W) ? POS_W - OFF_W : 1;
  localparam int LW        = POS_W + 1;
  localparam int EXT_W     = (POS_W > IDX_W) ? POS_W : IDX_W;
  localparam int CW        = (LW > CFG_W) ? LW : CFG_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WORD  = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;

  function automatic logic [OFF_W-1:0] low_idx(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [OFF_W-1:0]     r;
    iso = v & (~v + WORD_BITS'(1));
    r   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      r = r | (iso[i] ? OFF_W'(i) : '0);
    end
    return r;
  endfunction

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic                 first_r, first_nxt;
  logic                 res_old_r, res_old_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [POS_W-1:0]     res_pos_r, res_pos_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rd_q;

  logic [CMD_W-1:0]     in_cmd;
  logic [IDX_W-1:0]     in_bit_index;
  logic [POS_W-1:0]     in_pos;
  logic [CW-1:0]        cfg_ext;
  logic [LW-1:0]        lim, base, next_base;
  logic [WORD_BITS-1:0] bit_mask, lo_mask, lim_mask, cand;
  logic                 is_search, out_free;
  logic [EXT_W-1:0]     res_pos_ext;

  assign in_cmd       = in_tdata[CMD_W-1:0];
  assign in_bit_index = in_tdata[CMD_W+IDX_W-1:CMD_W];
  assign in_pos       = POS_W'(EXT_W'(in_bit_index));

  assign cfg_ext   = CW'(cfg_r);
  assign lim       = (cfg_ext > CW'(BITMAP_BITS)) ? LW'(BITMAP_BITS) : LW'(cfg_ext);
  assign base      = LW'(word_r) << OFF_W;
  assign next_base = base + LW'(WORD_BITS);

  assign bit_mask = WORD_BITS'(1) << off_r;
  assign lo_mask  = {WORD_BITS{1'b1}} << off_r;
  always_comb begin
    if (lim <= base) begin
      lim_mask = '0;
    end else if (lim >= next_base) begin
      lim_mask = {WORD_BITS{1'b1}};
    end else begin
      lim_mask = ~({WORD_BITS{1'b1}} << lim[OFF_W-1:0]);
    end
  end

  assign is_search = (cmd_r == CMD_FZERO) || (cmd_r == CMD_FONE);
  assign cand      = ((cmd_r == CMD_FONE) ? rd_q : ~rd_q) & lo_mask & lim_mask;
  assign out_free  = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign res_pos_ext = EXT_W'(res_pos_r);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    word_nxt       = word_r;
    off_nxt        = off_r;
    first_nxt      = first_r;
    res_old_nxt    = res_old_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = word_r;
    ram_wdata      = rd_q;
    ram_raddr      = word_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = AW'(in_pos >> OFF_W);
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          word_nxt  = AW'(in_pos >> OFF_W);
          off_nxt   = in_pos[OFF_W-1:0];
          first_nxt = 1'b1;
          state_nxt = ST_WORD;
        end
      end
      ST_WORD: begin
        ram_raddr = word_r + AW'(1);
        if (first_r) begin
          res_old_nxt = |(rd_q & bit_mask);
        end
        res_found_nxt = 1'b0;
        res_pos_nxt   = '0;
        if (is_search) begin
          if (|cand) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = POS_W'(base | LW'(low_idx(cand)));
            state_nxt     = ST_DONE;
          end else if (next_base < lim) begin
            word_nxt  = word_r + AW'(1);
            off_nxt   = '0;
            first_nxt = 1'b0;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          case (cmd_r) inside
            CMD_SET, CMD_TSET: begin
              ram_we    = 1'b1;
              ram_wdata = rd_q | bit_mask;
            end
            CMD_CLR, CMD_TCLR: begin
              ram_we    = 1'b1;
              ram_wdata = rd_q & ~bit_mask;
            end
            default: begin
            end
          endcase
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({res_pos_ext[IDX_W-1:0], res_found_r, res_old_r});
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      cfg_r        <= CFG_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    word_r      <= word_nxt;
    off_r       <= off_nxt;
    first_r     <= first_nxt;
    res_old_r   <= res_old_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  bbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .ADDR_W(AW)
  ) u_words (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_q)
  );

`include "assert_macros.svh"

  // searches never modify the bitmap
  `ASSERT_IMPL(a_search_no_write, (state_r == ST_WORD) && is_search, !ram_we)
  // a reported match lies below the search limit
  `ASSERT_IMPL(a_found_below_lim, (state_r == ST_DONE) && res_found_r,
               LW'(res_pos_r) < lim)
  // later words of a scan start below the limit
  `ASSERT_IMPL(a_scan_in_range, (state_r == ST_WORD) && !first_r, base < lim)
  // a finished request reaches the output register once it is free
  `ASSERT_NEXT(a_done_to_out, (state_r == ST_DONE) && out_free,
               out_tvalid_r && (state_r == ST_IDLE))

endmodule

/* sim/bitmap_bit_ops_and_search_unit_tb.sv */
// Self-checking testbench for the bitmap bit-op and search unit: directed and random requests.
`timescale 1ns / 1ps

module bitmap_bit_ops_and_search_unit_tb;
  import bbs_pkg::*;

  localparam int               NUM_BITS    = BITMAP_BITS_DEF;
  localparam int               STALL_LIMIT = 2000;
  localparam int               DRAIN_WAIT  = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] bit_index;
  } bm_req_t;

  typedef struct packed {
    logic             old_bit;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } bm_reply_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [2:0] cmd, [12:3] bit_index
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] old_bit, [1] found, [11:2] found_index
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = CFG_RESET;

  bm_req_t          cur_req = '0;
  bm_req_t          req_backlog[$];
  bm_reply_t        replies_due[$];
  bit [NUM_BITS-1:0] shadow_map = '0;
  logic [CFG_W-1:0] search_limit = CFG_RESET;
  int               open_reqs    = 0;
  int               mismatch_cnt = 0;
  int               quiet_cycles = 0;
  int               tx_idle_pct  = 0;
  int               rx_idle_pct  = 0;

  assign in_tdata = {{(IN_TDATA_W - CMD_W - IDX_W){1'b0}}, cur_req.bit_index, cur_req.cmd};

  bitmap_bit_ops_and_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow bitmap and returns the reply it should produce.
  function automatic bm_reply_t bitmap_apply(bm_req_t rq);
    bm_reply_t rep;
    int        lim;
    logic      want;
    rep         = '0;
    rep.old_bit = shadow_map[rq.bit_index];
    case (rq.cmd)
      CMD_SET, CMD_TSET: shadow_map[rq.bit_index] = 1'b1;
      CMD_CLR, CMD_TCLR: shadow_map[rq.bit_index] = 1'b0;
      CMD_FZERO, CMD_FONE: begin
        want = (rq.cmd == CMD_FONE);
        lim  = (search_limit > NUM_BITS) ? NUM_BITS : int'(search_limit);
        for (int p = int'(rq.bit_index); p < lim; p++) begin
          if (shadow_map[p] == want) begin
            rep.found       = 1'b1;
            rep.found_index = IDX_W'(p);
            break;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
    bm_req_t rq;
    rq.cmd       = cmd;
    rq.bit_index = idx;
    req_backlog.push_back(rq);
    open_reqs++;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  // Only called while nothing is in flight.
  task automatic write_bits_in_use(input logic [CFG_W-1:0] val);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    search_limit = val;
    cfg_valid   <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (open_reqs != 0);
  endtask

  // Mostly clustered traffic around a hot window so runs build up and searches scan far.
  task automatic gen_phase(input int n);
    int               made;
    int               kind;
    int               len;
    int               lim;
    logic [IDX_W-1:0] hot;
    logic [IDX_W-1:0] s;
    logic [CMD_W-1:0] op;
    made = 0;
    lim  = (search_limit > NUM_BITS) ? NUM_BITS : int'(search_limit);
    if (lim > 0 && $urandom_range(1) == 1)
      hot = IDX_W'($urandom_range(lim - 1));
    else
      hot = IDX_W'($urandom);
    while (made < n) begin
      kind = $urandom_range(99);
      s    = hot + IDX_W'($urandom_range(63));
      if (kind < 30) begin
        case ($urandom_range(10))
          0, 1:    op = CMD_TEST;
          2, 3:    op = CMD_SET;
          4, 5:    op = CMD_CLR;
          6, 7:    op = CMD_TSET;
          8, 9:    op = CMD_TCLR;
          default: op = CMD_UNUSED;
        endcase
        add_req(op, s);
        made++;
      end else if (kind < 55) begin
        add_req($urandom_range(1) ? CMD_FONE : CMD_FZERO, s - IDX_W'($urandom_range(8)));
        made++;
      end else if (kind < 80) begin
        // fill a run, then search for the opposite value from near its start
        len = $urandom_range(1, 40);
        op  = $urandom_range(1) ? CMD_SET : CMD_CLR;
        for (int k = 0; k < len; k++)
          add_req(op, s + IDX_W'(k));
        add_req((op == CMD_SET) ? CMD_FZERO : CMD_FONE, s - IDX_W'($urandom_range(3)));
        made += len + 1;
      end else begin
        add_req(CMD_W'($urandom_range(7)), IDX_W'($urandom));
        made++;
      end
    end
  endtask

  always @(posedge clk) begin : drive_proc
    bm_req_t nxt;
    logic    nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt       = cur_req;
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        replies_due.push_back(bitmap_apply(cur_req));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && req_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt       = req_backlog.pop_front();
        nxt_valid = 1'b1;
      end
      cur_req   <= nxt;
      in_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin : check_proc
    bm_reply_t got;
    bm_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.old_bit     = out_tdata[0];
        got.found       = out_tdata[1];
        got.found_index = out_tdata[11:2];
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply with no request pending: old=%0b found=%0b idx=%0d",
                                    got.old_bit, got.found, got.found_index));
        end else begin
          want = replies_due.pop_front();
          open_reqs--;
          if (got.old_bit !== want.old_bit || got.found !== want.found ||
              got.found_index !== want.found_index)
            report_mismatch($sformatf(
              "reply mismatch: exp old=%0b found=%0b idx=%0d, got old=%0b found=%0b idx=%0d",
              want.old_bit, want.found, want.found_index,
              got.old_bit, got.found, got.found_index));
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bitmap_bit_ops_and_search_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim_proc
    logic [CFG_W-1:0] cfg_val;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 13;
    rx_idle_pct = 51;

    // directed: empty map, every op, old_bit on searches, cross-word scans
    add_req(CMD_TEST, 10'd0);
    add_req(CMD_FONE, 10'd0);
    add_req(CMD_FZERO, 10'd1023);
    add_req(CMD_SET, 10'd0);
    add_req(CMD_SET, 10'd1023);
    add_req(CMD_TSET, 10'd1023);
    add_req(CMD_TSET, 10'd5);
    add_req(CMD_TCLR, 10'd5);
    add_req(CMD_TCLR, 10'd5);
    add_req(CMD_UNUSED, 10'd0);
    add_req(CMD_FONE, 10'd1);
    add_req(CMD_FZERO, 10'd0);
    add_req(CMD_CLR, 10'd1023);
    add_req(CMD_TEST, 10'd1023);
    add_req(CMD_FONE, 10'd1);
    add_req(CMD_SET, 10'h2AA);
    add_req(CMD_SET, 10'h155);
    add_req(CMD_FONE, 10'h156);
    add_req(CMD_FZERO, 10'h155);
    add_req(CMD_CLR, 10'd0);
    add_req(CMD_UNUSED, 10'd1023);
    add_req(CMD_FONE, 10'd0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 51;
      end else if (ph < 6) begin
        tx_idle_pct = 51;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // limit zero and limits above the bitmap are included on purpose
      case (ph)
        0:       cfg_val = 11'd1024;
        1:       cfg_val = 11'd1;
        2:       cfg_val = 11'd0;
        3:       cfg_val = 11'd2047;
        4:       cfg_val = 11'd700;
        5:       cfg_val = 11'd33;
        6:       cfg_val = 11'd1023;
        default: cfg_val = CFG_W'($urandom_range(1, 1024));
      endcase
      write_bits_in_use(cfg_val);
      gen_phase(60);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("bitmap_bit_ops_and_search_unit_tb: PASS");
    else
      $display("bitmap_bit_ops_and_search_unit_tb: FAIL");
    $finish;
  end

endmodule
